FILE: design/rth_pkg.sv
`timescale 1ns / 1ps

package rth_pkg;

  localparam int COMPONENT_BITS_DEF    = 8;
  localparam int HUE_FRACTION_BITS_DEF = 6;

  // degrees per hue sector and per full turn
  localparam int SECTOR_DEGREES = 60;
  localparam int TURN_DEGREES   = 360;

  localparam logic [1:0] SECT_RED   = 2'd0;
  localparam logic [1:0] SECT_GREEN = 2'd1;
  localparam logic [1:0] SECT_BLUE  = 2'd2;

  typedef struct packed {
    logic       defined;
    logic       neg;
    logic [1:0] sector;
  } rth_flags_t;

endpackage

FILE: design/rth_if.sv
`timescale 1ns / 1ps

interface rth_pix_if #(
  parameter int COMPONENT_BITS = rth_pkg::COMPONENT_BITS_DEF
);
  logic                      valid;
  logic                      ready;
  logic [COMPONENT_BITS-1:0] red_level;
  logic [COMPONENT_BITS-1:0] green_level;
  logic [COMPONENT_BITS-1:0] blue_level;

  modport source (output valid, output red_level, output green_level, output blue_level,
                  input ready);
  modport sink (input valid, input red_level, input green_level, input blue_level,
                output ready);
endinterface

interface rth_hsv_if #(
  parameter int COMPONENT_BITS    = rth_pkg::COMPONENT_BITS_DEF,
  parameter int HUE_FRACTION_BITS = rth_pkg::HUE_FRACTION_BITS_DEF
);
  logic                           valid;
  logic                           ready;
  logic [9+HUE_FRACTION_BITS-1:0] hue_angle;
  logic [COMPONENT_BITS-1:0]      saturation;
  logic [COMPONENT_BITS-1:0]      brightness;
  logic                           hue_defined;

  modport source (output valid, output hue_angle, output saturation, output brightness,
                  output hue_defined, input ready);
  modport sink (input valid, input hue_angle, input saturation, input brightness,
                input hue_defined, output ready);
endinterface

FILE: design/rth_front.sv
`timescale 1ns / 1ps

module rth_front #(
  parameter int COMPONENT_BITS    = rth_pkg::COMPONENT_BITS_DEF,
  parameter int HUE_FRACTION_BITS = rth_pkg::HUE_FRACTION_BITS_DEF,
  parameter int XW                = 2 * rth_pkg::COMPONENT_BITS_DEF + 4
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [COMPONENT_BITS-1:0] red,
  input  logic [COMPONENT_BITS-1:0] green,
  input  logic [COMPONENT_BITS-1:0] blue,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [XW-1:0]             sat_num,
  output logic [XW-1:0]             hue_num,
  output logic [COMPONENT_BITS-1:0] hi_out,
  output logic [COMPONENT_BITS-1:0] delta_out,
  output rth_pkg::rth_flags_t       flags
);
  localparam int CB       = COMPONENT_BITS;
  localparam int HueUnits = rth_pkg::SECTOR_DEGREES * (2 ** HUE_FRACTION_BITS);
  localparam logic [XW-1:0] FULL_X  = XW'((2 ** CB) - 1);
  localparam logic [XW-1:0] UNITS_X = XW'(HueUnits);

  // stage A: max, min, sector and difference operands
  logic          va;
  logic [CB-1:0] hi_a, lo_a, dp_a, dm_a;
  logic [1:0]    sector_a;
  // stage B: delta, numerators
  logic          vb;

  logic          go_a, go_b;
  logic [CB-1:0] hi_next, lo_next, dp_next, dm_next;
  logic [1:0]    sector_next;
  logic [CB-1:0] delta, mag;
  logic          neg;

  assign go_b      = !vb || out_ready;
  assign go_a      = !va || go_b;
  assign in_ready  = go_a;
  assign out_valid = vb;

  always_comb begin
    if (red >= green && red >= blue) begin
      sector_next = rth_pkg::SECT_RED;
      hi_next     = red;
      dp_next     = green;
      dm_next     = blue;
    end else if (green >= blue) begin
      sector_next = rth_pkg::SECT_GREEN;
      hi_next     = green;
      dp_next     = blue;
      dm_next     = red;
    end else begin
      sector_next = rth_pkg::SECT_BLUE;
      hi_next     = blue;
      dp_next     = red;
      dm_next     = green;
    end
    if (red <= green) begin
      lo_next = (red <= blue) ? red : blue;
    end else begin
      lo_next = (green <= blue) ? green : blue;
    end
  end

  always_comb begin
    delta = hi_a - lo_a;
    neg   = dp_a < dm_a;
    mag   = neg ? (dm_a - dp_a) : (dp_a - dm_a);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      va <= 1'b0;
    end else if (go_a) begin
      va <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (go_a) begin
      hi_a     <= hi_next;
      lo_a     <= lo_next;
      dp_a     <= dp_next;
      dm_a     <= dm_next;
      sector_a <= sector_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vb <= 1'b0;
    end else if (go_b) begin
      vb <= va;
    end
  end

  always_ff @(posedge clk) begin
    if (go_b) begin
      sat_num       <= XW'(delta) * FULL_X;
      hue_num       <= XW'(mag) * UNITS_X;
      hi_out        <= hi_a;
      delta_out     <= delta;
      flags.defined <= delta != '0;
      flags.neg     <= neg;
      flags.sector  <= sector_a;
    end
  end

endmodule

FILE: design/rth_divider.sv
`timescale 1ns / 1ps

module rth_divider #(
  parameter int COMPONENT_BITS = rth_pkg::COMPONENT_BITS_DEF,
  parameter int QW             = 12,
  parameter int XW             = rth_pkg::COMPONENT_BITS_DEF + 12
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [XW-1:0]             sat_num,
  input  logic [XW-1:0]             hue_num,
  input  logic [COMPONENT_BITS-1:0] hi,
  input  logic [COMPONENT_BITS-1:0] delta,
  input  rth_pkg::rth_flags_t       flags_in,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [QW-1:0]             sat_quot,
  output logic [QW-1:0]             hue_quot,
  output logic                      hue_rem_nz,
  output logic [COMPONENT_BITS-1:0] hi_out,
  output rth_pkg::rth_flags_t       flags_out
);
  localparam int CB = COMPONENT_BITS;

  // index 0 is the incoming beat, index j+1 the register after step j
  logic [QW:0]         v;
  logic [QW:0]         go;
  logic [XW-1:0]       rem_s [QW+1];
  logic [XW-1:0]       rem_h [QW+1];
  logic [QW-1:0]       q_s   [QW+1];
  logic [QW-1:0]       q_h   [QW+1];
  logic [CB-1:0]       hi_p  [QW+1];
  logic [CB-1:0]       dl_p  [QW+1];
  rth_pkg::rth_flags_t fl_p  [QW+1];

  assign v[0]     = in_valid;
  assign rem_s[0] = sat_num;
  assign rem_h[0] = hue_num;
  assign q_s[0]   = '0;
  assign q_h[0]   = '0;
  assign hi_p[0]  = hi;
  assign dl_p[0]  = delta;
  assign fl_p[0]  = flags_in;

  assign go[QW]   = out_ready;
  assign in_ready = go[0];

  generate
    for (genvar j = 0; j < QW; j++) begin : g_step
      localparam int B = QW - 1 - j;
      logic [XW-1:0] sh_s, sh_h;
      logic          fit_s, fit_h;
      logic [QW-1:0] qs_next, qh_next;

      assign go[j] = !v[j+1] || go[j+1];

      // restoring step: try the divisor shifted to this quotient bit
      always_comb begin
        sh_s    = XW'(hi_p[j]) << B;
        sh_h    = XW'(dl_p[j]) << B;
        fit_s   = rem_s[j] >= sh_s;
        fit_h   = rem_h[j] >= sh_h;
        qs_next = q_s[j];
        qh_next = q_h[j];
        qs_next[B] = fit_s;
        qh_next[B] = fit_h;
      end

      always_ff @(posedge clk) begin
        if (rst) begin
          v[j+1] <= 1'b0;
        end else if (go[j]) begin
          v[j+1] <= v[j];
        end
      end

      always_ff @(posedge clk) begin
        if (go[j]) begin
          rem_s[j+1] <= fit_s ? (rem_s[j] - sh_s) : rem_s[j];
          rem_h[j+1] <= fit_h ? (rem_h[j] - sh_h) : rem_h[j];
          q_s[j+1]   <= qs_next;
          q_h[j+1]   <= qh_next;
          hi_p[j+1]  <= hi_p[j];
          dl_p[j+1]  <= dl_p[j];
          fl_p[j+1]  <= fl_p[j];
        end
      end
    end
  endgenerate

  assign out_valid  = v[QW];
  assign sat_quot   = q_s[QW];
  assign hue_quot   = q_h[QW];
  assign hue_rem_nz = rem_h[QW] != '0;
  assign hi_out     = hi_p[QW];
  assign flags_out  = fl_p[QW];

endmodule

FILE: design/rth_back.sv
`timescale 1ns / 1ps

module rth_back #(
  parameter int COMPONENT_BITS    = rth_pkg::COMPONENT_BITS_DEF,
  parameter int HUE_FRACTION_BITS = rth_pkg::HUE_FRACTION_BITS_DEF,
  parameter int QW                = 12
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [QW-1:0]                  sat_quot,
  input  logic [QW-1:0]                  hue_quot,
  input  logic                           hue_rem_nz,
  input  logic [COMPONENT_BITS-1:0]      hi,
  input  rth_pkg::rth_flags_t            flags,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [9+HUE_FRACTION_BITS-1:0] hue_angle,
  output logic [COMPONENT_BITS-1:0]      saturation,
  output logic [COMPONENT_BITS-1:0]      brightness,
  output logic                           hue_defined
);
  localparam int HW       = 9 + HUE_FRACTION_BITS;
  localparam int HueUnits = rth_pkg::SECTOR_DEGREES * (2 ** HUE_FRACTION_BITS);
  localparam logic [HW:0] BASE_GREEN = (HW+1)'(2 * HueUnits);
  localparam logic [HW:0] BASE_BLUE  = (HW+1)'(4 * HueUnits);
  localparam logic [HW:0] HUE_TURN   =
    (HW+1)'(rth_pkg::TURN_DEGREES * (2 ** HUE_FRACTION_BITS));

  logic          go;
  logic [HW:0]   base, q_ext, hue_sum;

  assign go        = !out_valid || out_ready;
  assign in_ready  = go;

  always_comb begin
    q_ext = (HW+1)'(hue_quot);
    case (flags.sector)
      rth_pkg::SECT_RED:   base = '0;
      rth_pkg::SECT_GREEN: base = BASE_GREEN;
      rth_pkg::SECT_BLUE:  base = BASE_BLUE;
      default:             base = '0;
    endcase
    if (!flags.neg) begin
      hue_sum = base + q_ext;
    end else if (flags.sector == rth_pkg::SECT_RED) begin
      // a negative red-sector hue wraps around the full turn
      hue_sum = (q_ext != '0) ? (HUE_TURN - q_ext) : '0;
    end else begin
      // base plus a negative fraction stays positive and floors: round the quotient up
      hue_sum = base - q_ext - (HW+1)'(hue_rem_nz);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (go) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      hue_angle   <= flags.defined ? hue_sum[HW-1:0] : '0;
      saturation  <= flags.defined ? sat_quot[COMPONENT_BITS-1:0] : '0;
      brightness  <= hi;
      hue_defined <= flags.defined;
    end
  end

endmodule

FILE: design/rgb_to_hsv.sv
`timescale 1ns / 1ps
// Stages: front A, B, one divider step per quotient bit, the back stage; quotient width
//   QW = max(COMPONENT_BITS, clog2(60 * 2^HUE_FRACTION_BITS + 1)), 12 by default.
// Throughput: one pixel per cycle; the two dividers resolve one quotient bit per stage.
// Each stage holds under back-pressure and takes a new beat whenever its slot frees up.
// Reset (rst, synchronous) clears all valid bits; data registers are not reset.
module rgb_to_hsv #(
  parameter int COMPONENT_BITS    = rth_pkg::COMPONENT_BITS_DEF,
  parameter int HUE_FRACTION_BITS = rth_pkg::HUE_FRACTION_BITS_DEF
) (
  input logic       clk,
  input logic       rst,
  rth_pix_if.sink   pixel,
  rth_hsv_if.source hsv
);
  localparam int CB       = COMPONENT_BITS;
  localparam int HueUnits = rth_pkg::SECTOR_DEGREES * (2 ** HUE_FRACTION_BITS);
  localparam int HQ       = $clog2(HueUnits + 1);
  localparam int QW       = (CB > HQ) ? CB : HQ;
  localparam int XW       = CB + QW;

  logic                f_valid, f_ready;
  logic [XW-1:0]       f_sat_num, f_hue_num;
  logic [CB-1:0]       f_hi, f_delta;
  rth_pkg::rth_flags_t f_flags;

  logic                d_valid, d_ready;
  logic [QW-1:0]       d_sat_quot, d_hue_quot;
  logic                d_hue_rem_nz;
  logic [CB-1:0]       d_hi;
  rth_pkg::rth_flags_t d_flags;

  rth_front #(
    .COMPONENT_BITS   (CB),
    .HUE_FRACTION_BITS(HUE_FRACTION_BITS),
    .XW               (XW)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (pixel.valid),
    .in_ready (pixel.ready),
    .red      (pixel.red_level),
    .green    (pixel.green_level),
    .blue     (pixel.blue_level),
    .out_valid(f_valid),
    .out_ready(f_ready),
    .sat_num  (f_sat_num),
    .hue_num  (f_hue_num),
    .hi_out   (f_hi),
    .delta_out(f_delta),
    .flags    (f_flags)
  );

  rth_divider #(
    .COMPONENT_BITS(CB),
    .QW            (QW),
    .XW            (XW)
  ) u_divider (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (f_valid),
    .in_ready  (f_ready),
    .sat_num   (f_sat_num),
    .hue_num   (f_hue_num),
    .hi        (f_hi),
    .delta     (f_delta),
    .flags_in  (f_flags),
    .out_valid (d_valid),
    .out_ready (d_ready),
    .sat_quot  (d_sat_quot),
    .hue_quot  (d_hue_quot),
    .hue_rem_nz(d_hue_rem_nz),
    .hi_out    (d_hi),
    .flags_out (d_flags)
  );

  rth_back #(
    .COMPONENT_BITS   (CB),
    .HUE_FRACTION_BITS(HUE_FRACTION_BITS),
    .QW               (QW)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (d_valid),
    .in_ready   (d_ready),
    .sat_quot   (d_sat_quot),
    .hue_quot   (d_hue_quot),
    .hue_rem_nz (d_hue_rem_nz),
    .hi         (d_hi),
    .flags      (d_flags),
    .out_valid  (hsv.valid),
    .out_ready  (hsv.ready),
    .hue_angle  (hsv.hue_angle),
    .saturation (hsv.saturation),
    .brightness (hsv.brightness),
    .hue_defined(hsv.hue_defined)
  );

endmodule

FILE: design/rth_checker.sv
`timescale 1ns / 1ps

module rth_checker #(
  parameter int COMPONENT_BITS    = rth_pkg::COMPONENT_BITS_DEF,
  parameter int HUE_FRACTION_BITS = rth_pkg::HUE_FRACTION_BITS_DEF
) (
  input logic                           clk,
  input logic                           rst,
  input logic                           valid,
  input logic                           ready,
  input logic [9+HUE_FRACTION_BITS-1:0] hue_angle,
  input logic [COMPONENT_BITS-1:0]      saturation,
  input logic [COMPONENT_BITS-1:0]      brightness,
  input logic                           hue_defined
);
  localparam int HW = 9 + HUE_FRACTION_BITS;
  localparam logic [HW-1:0] HUE_TURN =
    HW'(rth_pkg::TURN_DEGREES * (2 ** HUE_FRACTION_BITS));

  // a stalled result beat holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    valid && !ready |=> valid && $stable(hue_angle) && $stable(saturation)
                        && $stable(brightness) && $stable(hue_defined))
    else $error("result beat changed while stalled");

  a_reset: assert property (@(posedge clk) rst |=> !valid)
    else $error("result valid right after reset");

  a_grey: assert property (@(posedge clk) disable iff (rst)
    valid && !hue_defined |-> hue_angle == '0 && saturation == '0)
    else $error("grey pixel with nonzero hue or saturation");

  a_color: assert property (@(posedge clk) disable iff (rst)
    valid && hue_defined |-> saturation != '0 && brightness != '0)
    else $error("colored pixel with zero saturation or brightness");

  a_range: assert property (@(posedge clk) disable iff (rst)
    valid |-> hue_angle < HUE_TURN)
    else $error("hue beyond full turn");

endmodule

bind rgb_to_hsv rth_checker #(
  .COMPONENT_BITS   (COMPONENT_BITS),
  .HUE_FRACTION_BITS(HUE_FRACTION_BITS)
) u_rth_checker (
  .clk        (clk),
  .rst        (rst),
  .valid      (hsv.valid),
  .ready      (hsv.ready),
  .hue_angle  (hsv.hue_angle),
  .saturation (hsv.saturation),
  .brightness (hsv.brightness),
  .hue_defined(hsv.hue_defined)
);

FILE: dv/hsv_checker.sv
`timescale 1ns / 1ps

module hsv_checker (
  input  logic        clk,
  input  logic        rst,
  rth_pix_if          pix,
  rth_hsv_if          hsv,
  output int unsigned mismatches,
  output int unsigned results_due
);
  localparam int CB   = rth_pkg::COMPONENT_BITS_DEF;
  localparam int HF   = rth_pkg::HUE_FRACTION_BITS_DEF;
  localparam int FULL = (1 << CB) - 1;

  typedef struct {
    logic [9+HF-1:0] hue_angle;
    logic [CB-1:0]   saturation;
    logic [CB-1:0]   brightness;
    logic            hue_defined;
  } hsv_t;

  hsv_t hsv_due_q[$];
  int unsigned err_count = 0;

  function automatic hsv_t convert_pixel(logic [CB-1:0] r, logic [CB-1:0] g,
                                         logic [CB-1:0] b);
    hsv_t       px;
    int         hi, lo, delta, diff, hue;
    logic [1:0] sector;
    hi = (r > g) ? int'(r) : int'(g);
    hi = (hi > int'(b)) ? hi : int'(b);
    lo = (r < g) ? int'(r) : int'(g);
    lo = (lo < int'(b)) ? lo : int'(b);
    delta = hi - lo;
    px.brightness = hi[CB-1:0];
    if (delta == 0) begin
      px.hue_angle   = '0;
      px.saturation  = '0;
      px.hue_defined = 1'b0;
      return px;
    end
    px.saturation = CB'((FULL * delta) / hi);
    // ties go to the earlier component: red, then green, then blue
    if (int'(r) >= hi) begin
      sector = rth_pkg::SECT_RED;
      diff   = int'(g) - int'(b);
    end else if (int'(g) >= hi) begin
      sector = rth_pkg::SECT_GREEN;
      diff   = int'(b) - int'(r);
    end else begin
      sector = rth_pkg::SECT_BLUE;
      diff   = int'(r) - int'(g);
    end
    // int division truncates toward zero; wrap negatives afterwards
    hue = ((rth_pkg::SECTOR_DEGREES << HF) * (2 * int'(sector) * delta + diff)) / delta;
    if (hue < 0) hue += (rth_pkg::TURN_DEGREES << HF);
    px.hue_angle   = hue[9+HF-1:0];
    px.hue_defined = 1'b1;
    return px;
  endfunction

  task automatic report(string what, int got, int want);
    err_count++;
    if (err_count <= 100)
      $display("%0t: %s mismatch: got %0d, expected %0d", $realtime, what, got, want);
  endtask

  always @(posedge clk) begin
    hsv_t want;
    if (!rst) begin
      // check the result beat before queuing this edge's pixel beat
      if (hsv.valid && hsv.ready) begin
        if (hsv_due_q.size() == 0) begin
          report("unexpected result beat, hue", int'(hsv.hue_angle), 0);
        end else begin
          want = hsv_due_q.pop_front();
          if (hsv.hue_angle !== want.hue_angle)
            report("hue_angle", int'(hsv.hue_angle), int'(want.hue_angle));
          if (hsv.saturation !== want.saturation)
            report("saturation", int'(hsv.saturation), int'(want.saturation));
          if (hsv.brightness !== want.brightness)
            report("brightness", int'(hsv.brightness), int'(want.brightness));
          if (hsv.hue_defined !== want.hue_defined)
            report("hue_defined", int'(hsv.hue_defined), int'(want.hue_defined));
        end
      end
      if (pix.valid && pix.ready)
        hsv_due_q.push_back(convert_pixel(pix.red_level, pix.green_level, pix.blue_level));
    end
    mismatches  <= err_count;
    results_due <= hsv_due_q.size();
  end

  initial begin
    mismatches  = 0;
    results_due = 0;
  end

endmodule

FILE: dv/testbench.sv
`timescale 1ns / 1ps

module testbench;
  localparam int CB          = rth_pkg::COMPONENT_BITS_DEF;
  localparam int HF          = rth_pkg::HUE_FRACTION_BITS_DEF;
  localparam int PHASE_BEATS = 460;
  localparam int DRAIN_WAIT  = 40;
  localparam int STALL_LEN   = 80;
  localparam int CYCLE_LIMIT = 300000;

  logic clk;
  logic rst;

  int unsigned fail_count;
  int unsigned results_due;
  int          send_idle = 0;
  int          recv_idle = 0;
  bit          stall_request = 0;
  int          stall_left = 0;
  int unsigned cycle_count = 0;

  rth_pix_if #(.COMPONENT_BITS(CB)) pix_bus ();
  rth_hsv_if #(.COMPONENT_BITS(CB), .HUE_FRACTION_BITS(HF)) hsv_bus ();

  rgb_to_hsv #(.COMPONENT_BITS(CB), .HUE_FRACTION_BITS(HF)) dut (
    .clk   (clk),
    .rst   (rst),
    .pixel (pix_bus),
    .hsv   (hsv_bus)
  );

  hsv_checker chk (
    .clk         (clk),
    .rst         (rst),
    .pix         (pix_bus),
    .hsv         (hsv_bus),
    .mismatches  (fail_count),
    .results_due (results_due)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  // result side: random idling plus an occasional long hold-off
  always @(posedge clk) begin
    if (stall_request) begin
      stall_request = 0;
      stall_left    = STALL_LEN;
    end
    if (rst) begin
      hsv_bus.ready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      hsv_bus.ready <= 1'b0;
    end else begin
      hsv_bus.ready <= ($urandom_range(99) >= recv_idle);
    end
  end

  task automatic send_pixel(input logic [CB-1:0] r, input logic [CB-1:0] g,
                            input logic [CB-1:0] b);
    while ($urandom_range(99) < send_idle) begin
      pix_bus.valid <= 1'b0;
      @(posedge clk);
    end
    pix_bus.valid       <= 1'b1;
    pix_bus.red_level   <= r;
    pix_bus.green_level <= g;
    pix_bus.blue_level  <= b;
    @(posedge clk);
    while (!pix_bus.ready) @(posedge clk);
  endtask

  // hold the input until every pending result has come out
  task automatic drain();
    pix_bus.valid <= 1'b0;
    @(posedge clk);
    while (results_due != 0) @(posedge clk);
  endtask

  function automatic logic [CB-1:0] edge_level();
    case ($urandom_range(4))
      0:       return '0;
      1:       return CB'(1);
      2:       return {CB{1'b1}} - 1'b1;
      3:       return {CB{1'b1}};
      default: return CB'($urandom);
    endcase
  endfunction

  task automatic send_random();
    logic [CB-1:0] a, c, d;
    int            spread;
    a = CB'($urandom);
    c = CB'($urandom);
    d = CB'($urandom);
    case ($urandom_range(9))
      5, 6: begin
        // two components equal: exercises the sector tie-break
        case ($urandom_range(2))
          0:       send_pixel(a, a, c);
          1:       send_pixel(c, a, a);
          default: send_pixel(a, c, a);
        endcase
      end
      7: send_pixel(a, a, a);
      8: send_pixel(edge_level(), edge_level(), edge_level());
      9: begin
        // nearly grey: small delta, large hue steps
        spread = $urandom_range(3);
        send_pixel(a, CB'(a + $urandom_range(spread)), CB'(a - $urandom_range(spread)));
      end
      default: send_pixel(a, c, d);
    endcase
  endtask

  initial begin
    rst                 = 1'b1;
    pix_bus.valid       = 1'b0;
    pix_bus.red_level   = '0;
    pix_bus.green_level = '0;
    pix_bus.blue_level  = '0;
    hsv_bus.ready       = 1'b0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // greys, primaries, ties, wrap below zero, extreme saturation
    send_pixel(8'd0,   8'd0,   8'd0);
    send_pixel(8'd255, 8'd255, 8'd255);
    send_pixel(8'd128, 8'd128, 8'd128);
    send_pixel(8'd255, 8'd0,   8'd0);
    send_pixel(8'd0,   8'd255, 8'd0);
    send_pixel(8'd0,   8'd0,   8'd255);
    send_pixel(8'd255, 8'd255, 8'd0);
    send_pixel(8'd0,   8'd255, 8'd255);
    send_pixel(8'd255, 8'd0,   8'd255);
    send_pixel(8'd255, 8'd0,   8'd1);
    send_pixel(8'd255, 8'd1,   8'd0);
    send_pixel(8'd1,   8'd0,   8'd0);
    send_pixel(8'd255, 8'd254, 8'd254);
    send_pixel(8'd1,   8'd0,   8'd2);
    send_pixel(8'd0,   8'd2,   8'd1);
    send_pixel(8'd200, 8'd100, 8'd50);
    send_pixel(8'd50,  8'd200, 8'd100);
    send_pixel(8'd100, 8'd50,  8'd200);
    send_pixel(8'd170, 8'd85,  8'd255);
    send_pixel(8'd85,  8'd170, 8'd0);
    drain();

    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin send_idle = 21; recv_idle = 64; end
        1: begin send_idle = 64; recv_idle = 21; end
        default: begin send_idle = 0; recv_idle = 0; end
      endcase
      for (int i = 0; i < PHASE_BEATS; i++) begin
        if (phase == 2 && i == PHASE_BEATS / 2) stall_request = 1;
        send_random();
      end
      drain();
    end

    repeat (DRAIN_WAIT) @(posedge clk);
    if (fail_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
